/* rtl/tfc_pkg.sv */
`timescale 1ns / 1ps

package tfc_pkg;

  // sample format: signed fixed point, 1 g at 2**FRAC_BITS
  localparam int AXIS_BITS   = 16;
  localparam int FRAC_BITS   = 12;
  localparam int MARGIN_BITS = 13;
  localparam int FACE_BITS   = 3;

  // configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 13;

  // compare width: room for |+-1 g - axis| and for 1 g - margin going negative
  localparam int WIDE_A = (AXIS_BITS > FRAC_BITS + 1) ? AXIS_BITS : FRAC_BITS + 1;
  localparam int WIDE_B = (WIDE_A > MARGIN_BITS + 1) ? WIDE_A : MARGIN_BITS + 1;
  localparam int CMP_W  = WIDE_B + 3;

  typedef logic signed [CMP_W-1:0] cmp_t;

  localparam cmp_t ONE_G = cmp_t'(2 ** FRAC_BITS);

  // about 0.4 g
  localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'((4 * (2 ** FRAC_BITS)) / 10);

  localparam logic [FACE_BITS-1:0] FACE_UNKNOWN = FACE_BITS'(0);
  localparam logic [FACE_BITS-1:0] FACE_MAX     = FACE_BITS'(6);
  localparam int                   NUM_FACES    = 6;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TILT_MARGIN = 1'b0,
    REG_START_FACE  = 1'b1
  } reg_index_t;

  // one component of a face unit vector
  typedef enum logic [1:0] {
    COMP_ZERO,
    COMP_POS,
    COMP_NEG
  } comp_t;

  typedef struct packed {
    comp_t x;
    comp_t y;
    comp_t z;
  } face_vec_t;

  // unit vector of each face, unknown face sits at the origin
  function automatic face_vec_t face_vec(input logic [FACE_BITS-1:0] face);
    face_vec_t v;
    v = '{x: COMP_ZERO, y: COMP_ZERO, z: COMP_ZERO};
    case (face)
      3'd1:    v.z = COMP_POS;
      3'd2:    v.x = COMP_POS;
      3'd3:    v.y = COMP_POS;
      3'd4:    v.y = COMP_NEG;
      3'd5:    v.x = COMP_NEG;
      3'd6:    v.z = COMP_NEG;
      default: v = '{x: COMP_ZERO, y: COMP_ZERO, z: COMP_ZERO};
    endcase
    return v;
  endfunction

  function automatic cmp_t abs_cmp(input cmp_t v);
    return (v < 0) ? -v : v;
  endfunction

endpackage

/* rtl/tfc_accel_if.sv */
`timescale 1ns / 1ps

interface tfc_accel_if;
  import tfc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic signed [AXIS_BITS-1:0] accel_x;
  logic signed [AXIS_BITS-1:0] accel_y;
  logic signed [AXIS_BITS-1:0] accel_z;

  modport source (output valid, output accel_x, output accel_y, output accel_z, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z, output ready);
endinterface

/* rtl/tfc_face_if.sv */
`timescale 1ns / 1ps

interface tfc_face_if;
  import tfc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FACE_BITS-1:0] face_now;
  logic                 band_left;

  modport source (output valid, output face_now, output band_left, input ready);
  modport sink   (input valid, input face_now, input band_left, output ready);
endinterface

/* rtl/tilt_face_classifier.sv */
`timescale 1ns / 1ps

// Cube face tracker for a three-axis accelerometer.
// accel: one sample per transfer, signed fixed point, 1 g = 2**FRAC_BITS.
// face: one result per sample, the held face (0 unknown, 1 to 6) and a flag
//   set when the sample left the band of the held face and the six faces
//   were tested again.
// cfg: write port; register 0 is the hysteresis margin, register 1 loads
//   the held face (a value of 7 loads the unknown face). Write only while
//   no sample is in flight.
// The sample sits in the input register while the band and face compares
//   feed the result register, which also updates the held face.
// Throughput is one sample per cycle while the receiver takes each result;
//   the held face feedback closes within the single compare stage, so
//   consecutive samples never wait on it.
// When the receiver stalls, the result register holds and the input
//   register still takes one more sample, after which accel.ready drops.
// Reset (rst, synchronous) empties both registers, sets the margin to
//   about 0.4 g and the held face to unknown.
module tilt_face_classifier (
  input  logic                                clk,
  input  logic                                rst,
  tfc_accel_if.sink                           accel,
  tfc_face_if.source                          face,
  input  logic                                cfg_wen,
  input  logic [tfc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [tfc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
  import tfc_pkg::*;

  logic                        s1_valid;
  logic signed [AXIS_BITS-1:0] s1_x;
  logic signed [AXIS_BITS-1:0] s1_y;
  logic signed [AXIS_BITS-1:0] s1_z;

  logic [MARGIN_BITS-1:0] margin;
  logic [FACE_BITS-1:0]   held_face;

  logic                 out_free;
  logic                 load_s1;
  logic                 load_out;
  logic                 fire;
  logic [FACE_BITS-1:0] face_sel;

  // handshake: output register frees up, input register follows
  assign out_free    = !face.valid || face.ready;
  assign accel.ready = !s1_valid || out_free;
  assign load_s1     = accel.valid && accel.ready;
  assign load_out    = s1_valid && out_free;

  // band test and face search
  always_comb begin
    cmp_t      a [3];
    logic      oob_zero [3];
    logic      oob_pos [3];
    logic      oob_neg [3];
    logic      near_zero [3];
    logic      near_pos [3];
    logic      near_neg [3];
    comp_t     comp [3];
    logic      oob;
    logic      ok;
    cmp_t      m;
    cmp_t      lim;
    face_vec_t hv;
    face_vec_t kv;

    a[0] = cmp_t'(s1_x);
    a[1] = cmp_t'(s1_y);
    a[2] = cmp_t'(s1_z);
    m    = cmp_t'(margin);
    lim  = ONE_G - m;

    for (int i = 0; i < 3; i++) begin
      oob_zero[i]  = (a[i] < -m) || (a[i] > m);
      oob_pos[i]   = a[i] < lim;
      oob_neg[i]   = a[i] > -lim;
      near_zero[i] = abs_cmp(a[i]) < lim;
      near_pos[i]  = abs_cmp(ONE_G - a[i]) < lim;
      near_neg[i]  = abs_cmp(-ONE_G - a[i]) < lim;
    end

    // band around the held face
    hv = face_vec(held_face);
    comp[0] = hv.x;
    comp[1] = hv.y;
    comp[2] = hv.z;
    fire = 1'b0;
    for (int i = 0; i < 3; i++) begin
      case (comp[i])
        COMP_POS: oob = oob_pos[i];
        COMP_NEG: oob = oob_neg[i];
        default:  oob = oob_zero[i];
      endcase
      fire = fire || oob;
    end

    // last matching face wins, none keeps the held face
    face_sel = held_face;
    if (fire) begin
      for (int k = 1; k <= NUM_FACES; k++) begin
        kv = face_vec(FACE_BITS'(k));
        comp[0] = kv.x;
        comp[1] = kv.y;
        comp[2] = kv.z;
        ok = 1'b1;
        for (int i = 0; i < 3; i++) begin
          case (comp[i])
            COMP_POS: ok = ok && near_pos[i];
            COMP_NEG: ok = ok && near_neg[i];
            default:  ok = ok && near_zero[i];
          endcase
        end
        if (ok) begin
          face_sel = FACE_BITS'(k);
        end
      end
    end
  end

  // control, held face and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      face.valid <= 1'b0;
      margin     <= MARGIN_RESET;
      held_face  <= FACE_UNKNOWN;
    end else begin
      if (accel.ready) begin
        s1_valid <= accel.valid;
      end
      if (out_free) begin
        face.valid <= s1_valid;
      end
      if (cfg_wen) begin
        case (reg_index_t'(cfg_index))
          REG_TILT_MARGIN: margin <= cfg_data[MARGIN_BITS-1:0];
          REG_START_FACE: begin
            held_face <= (cfg_data[FACE_BITS-1:0] > FACE_MAX) ? FACE_UNKNOWN
                                                              : cfg_data[FACE_BITS-1:0];
          end
          default: ;
        endcase
      end else if (load_out) begin
        held_face <= face_sel;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (load_s1) begin
      s1_x <= accel.accel_x;
      s1_y <= accel.accel_y;
      s1_z <= accel.accel_z;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      face.face_now  <= face_sel;
      face.band_left <= fire;
    end
  end

  // both stages empty right after reset
  assert property (@(posedge clk) $past(rst) |-> !s1_valid && !face.valid)
    else $error("pipeline not empty after reset");

  // input side only blocks when both registers are full and the result is stalled
  assert property (@(posedge clk) disable iff (rst)
    !accel.ready |-> s1_valid && face.valid && !face.ready)
    else $error("input stalled without a full pipeline");

  // the delivered face is the held face
  assert property (@(posedge clk) disable iff (rst)
    load_out && !cfg_wen |=> face.face_now == held_face)
    else $error("result face differs from held face");

  // no band exit, no face change
  assert property (@(posedge clk) disable iff (rst)
    load_out && !fire && !cfg_wen |=> $stable(held_face))
    else $error("held face changed without band exit");

endmodule
